### sv/ccf_pkg.sv
`timescale 1ns / 1ps

package ccf_pkg;

   // Default line length of the line memories.
   localparam int MaxWidthDefault = 1024;

   // Field widths.
   localparam int PixW    = 8;
   localparam int CoefW   = 12;
   localparam int RowW    = 3 * CoefW;
   localparam int WidthW  = 11;
   localparam int HeightW = 16;
   localparam int IndexW  = 3;

   // Product of a Q4.8 coefficient and a pixel, and the sum of nine of them.
   localparam int ProdW = CoefW + PixW + 1;
   localparam int SumW  = ProdW + 3;

   // Reset values of the configuration registers.
   localparam logic [RowW-1:0]    CoefTopReset    = 36'hF00E00F00;
   localparam logic [RowW-1:0]    CoefMiddleReset = 36'h000000000;
   localparam logic [RowW-1:0]    CoefBottomReset = 36'h100200100;
   localparam logic [WidthW-1:0]  WidthReset      = 11'd640;
   localparam logic [HeightW-1:0] HeightReset     = 16'd480;

   typedef enum logic [IndexW-1:0] {
      REG_COEF_TOP    = 3'd0,
      REG_COEF_MIDDLE = 3'd1,
      REG_COEF_BOTTOM = 3'd2,
      REG_IMAGE_WIDTH = 3'd3,
      REG_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   // What one input transaction does as it moves down the pipeline.
   typedef struct packed {
      logic write_px;     // pixel transaction: update line memories and window
      logic emit_a;       // first result present
      logic zero_a;       // first result is a border zero
      logic row_end_a;
      logic image_end_a;
      logic emit_b;       // second result: right-border zero closing a row
   } item_type;

endpackage

### sv/ccf_if.sv
`timescale 1ns / 1ps

interface ccf_req_if;
   logic                      valid;
   logic                      ready;
   logic [ccf_pkg::PixW-1:0]  pixel_in;
   logic                      drain;

   modport source (output valid, pixel_in, drain, input ready);
   modport sink (input valid, pixel_in, drain, output ready);
endinterface

interface ccf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ccf_pkg::PixW-1:0]  pixel_out;
   logic                      row_end;
   logic                      image_end;

   modport source (output valid, pixel_out, row_end, image_end, input ready);
   modport sink (input valid, pixel_out, row_end, image_end, output ready);
endinterface

interface ccf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ccf_pkg::IndexW-1:0]  reg_index;
   logic [ccf_pkg::RowW-1:0]    wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### sv/ccf_line_ram.sv
`timescale 1ns / 1ps

module ccf_line_ram #(
   parameter int Depth = ccf_pkg::MaxWidthDefault,
   parameter int AddrW = $clog2(Depth)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AddrW-1:0]         wr_addr,
   input  logic [ccf_pkg::PixW-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [AddrW-1:0]         rd_addr,
   output logic [ccf_pkg::PixW-1:0] rd_data
);

   logic [ccf_pkg::PixW-1:0] mem [Depth];
   logic [ccf_pkg::PixW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ccf_sequencer.sv
`timescale 1ns / 1ps

module ccf_sequencer #(
   parameter int ColW = $clog2(ccf_pkg::MaxWidthDefault)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        drain,
   input  logic [ColW-1:0]             w_last,
   input  logic [ccf_pkg::HeightW-1:0] h_eff,
   output ccf_pkg::item_type           item,
   output logic [ColW-1:0]             col
);

   logic [ColW-1:0]             col_ff, col_in;
   logic [ccf_pkg::HeightW-1:0] row_ff, row_in;
   logic [ColW-1:0]             drain_ff, drain_in;
   logic [ccf_pkg::HeightW-1:0] row_inc;
   logic                        in_drain_phase;
   logic                        col_last;
   logic                        drain_last;
   logic                        row_nz;

   always_comb begin
      in_drain_phase = row_ff >= h_eff;
      col_last       = col_ff >= w_last;
      drain_last     = drain_ff >= w_last;
      row_nz         = row_ff != '0;
      row_inc        = row_ff + 16'd1;

      item     = '0;
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;

      if (in_drain_phase) begin
         if (drain) begin
            item.emit_a      = 1'b1;
            item.zero_a      = 1'b1;
            item.row_end_a   = drain_last;
            item.image_end_a = drain_last;
            if (drain_last) begin
               row_in   = '0;
               col_in   = '0;
               drain_in = '0;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
      end else if (!drain) begin
         item.write_px = 1'b1;
         item.emit_a   = row_nz && (col_ff != '0);
         // Only outputs off the border are filtered.
         item.zero_a   = !((row_ff >= 16'd2) && (col_ff >= ColW'(2)) && (col_ff <= w_last));
         item.emit_b   = row_nz && col_last;
         if (col_last) begin
            col_in = '0;
            row_in = row_inc;
            if (row_inc >= h_eff) begin
               drain_in = '0;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else if (accept) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

   assign col = col_ff;

endmodule

### sv/ccf_filter.sv
`timescale 1ns / 1ps

module ccf_filter (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic                       prod_en,
   input  logic [3*ccf_pkg::PixW-1:0] cur,
   input  logic [ccf_pkg::RowW-1:0]   coef_top,
   input  logic [ccf_pkg::RowW-1:0]   coef_middle,
   input  logic [ccf_pkg::RowW-1:0]   coef_bottom,
   output logic [ccf_pkg::PixW-1:0]   pixel_val
);

   localparam int PixW  = ccf_pkg::PixW;
   localparam int CoefW = ccf_pkg::CoefW;
   localparam int ProdW = ccf_pkg::ProdW;
   localparam int SumW  = ccf_pkg::SumW;

   // Previous two columns of the window; each holds rows r-2, r-1, r from low bits up.
   logic [3*PixW-1:0]        win_left_ff;
   logic [3*PixW-1:0]        win_mid_ff;
   logic [ccf_pkg::RowW-1:0] coef_rows [3];
   logic [3*PixW-1:0]        cols [3];
   logic signed [ProdW-1:0]  prod_in [9];
   logic signed [ProdW-1:0]  prod_ff [9];
   logic signed [SumW-1:0]   sum;

   always_comb begin
      coef_rows[0] = coef_top;
      coef_rows[1] = coef_middle;
      coef_rows[2] = coef_bottom;
      cols[0]      = win_left_ff;
      cols[1]      = win_mid_ff;
      cols[2]      = cur;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = $signed(coef_rows[r][CoefW*c +: CoefW])
                           * $signed({1'b0, cols[c][PixW*r +: PixW]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_left_ff <= win_mid_ff;
         win_mid_ff  <= cur;
      end
      if (prod_en) begin
         prod_ff <= prod_in;
      end
   end

   // Sum of the registered products, then clamp of the Q.8 result.
   always_comb begin
      sum = '0;
      for (int k = 0; k < 9; k++) begin
         sum = sum + SumW'(prod_ff[k]);
      end
      if (sum < 0) begin
         pixel_val = '0;
      end else if (sum[SumW-1:PixW] > (SumW-PixW)'(255)) begin
         pixel_val = '1;
      end else begin
         pixel_val = sum[2*PixW-1:PixW];
      end
   end

endmodule

### sv/ccf_out_stage.sv
`timescale 1ns / 1ps

module ccf_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ccf_pkg::item_type        item,
   input  logic [ccf_pkg::PixW-1:0] pixel_val,
   output logic                     free,
   ccf_rsp_if.source                rsp_chan
);

   logic                     pend_a_ff, pend_a_in;
   logic                     pend_b_ff, pend_b_in;
   logic [ccf_pkg::PixW-1:0] a_pix_ff;
   logic                     a_row_end_ff;
   logic                     a_image_end_ff;
   logic                     take;
   logic                     load;

   always_comb begin
      take = rsp_chan.valid && rsp_chan.ready;
      // Free once the last pending result goes out this cycle.
      free = !(pend_a_ff || pend_b_ff) || (take && !(pend_a_ff && pend_b_ff));
      load = in_valid && free;
      pend_a_in = pend_a_ff && !take;
      pend_b_in = pend_b_ff && !(take && !pend_a_ff);
      if (load) begin
         pend_a_in = item.emit_a;
         pend_b_in = item.emit_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
      end else begin
         pend_a_ff <= pend_a_in;
         pend_b_ff <= pend_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_pix_ff       <= item.zero_a ? '0 : pixel_val;
         a_row_end_ff   <= item.row_end_a;
         a_image_end_ff <= item.image_end_a;
      end
   end

   // The second result is always the right-border zero that closes a row.
   assign rsp_chan.valid     = pend_a_ff || pend_b_ff;
   assign rsp_chan.pixel_out = pend_a_ff ? a_pix_ff : '0;
   assign rsp_chan.row_end   = pend_a_ff ? a_row_end_ff : 1'b1;
   assign rsp_chan.image_end = pend_a_ff ? a_image_end_ff : 1'b0;

endmodule

### sv/conv3x3_clamped_filter.sv
`timescale 1ns / 1ps

// Streaming 3x3 convolution over 8-bit grey pixels in raster order. Each
// pixel transaction off the first row and column produces the output pixel
// one row above and one column to the left of it; a last-column pixel of
// a later row also produces the zero that closes its output row, so it
// yields two result transactions. Border outputs are zero, interior
// outputs are the Q4.8 weighted sum clamped to 0..255 (truncated). After
// the last pixel of an image, one drain transaction per pixel flushes the
// final all-zero output row; the last one carries image_end and the block
// is then ready for a new image. Drain transactions arriving while pixels
// are expected, and pixels arriving while the block drains, are consumed
// without result. The block takes one input transaction per clock unless
// the result port, which moves one result per clock while its receiver is
// ready, holds it back. Between input and result register lie the line
// memory read, the nine-multiplier stage and the adder and clamp stage.
// Two MAX_WIDTH x 8 line memories hold the previous two input rows; they
// need no clearing after reset, as unwritten entries only ever reach
// border outputs. Configuration is written through the csr channel, which
// is always ready, and must only be changed while the block is idle.
module conv3x3_clamped_filter #(
   parameter int MAX_WIDTH = ccf_pkg::MaxWidthDefault
) (
   input  logic      clock,
   input  logic      reset,
   ccf_req_if.sink   req_chan,
   ccf_rsp_if.source rsp_chan,
   ccf_csr_if.sink   csr_chan
);

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int PixW = ccf_pkg::PixW;

   // Configuration registers.
   logic [ccf_pkg::RowW-1:0]    coef_top_ff;
   logic [ccf_pkg::RowW-1:0]    coef_middle_ff;
   logic [ccf_pkg::RowW-1:0]    coef_bottom_ff;
   logic [ccf_pkg::WidthW-1:0]  width_ff;
   logic [ccf_pkg::HeightW-1:0] height_ff;

   // Effective geometry after range limiting.
   logic [ColW-1:0]             w_last;
   logic [ccf_pkg::HeightW-1:0] h_eff;

   // Pipeline control.
   logic en1;
   logic en2;
   logic req_fire;
   logic out_free;

   // Stage 0 decode.
   ccf_pkg::item_type seq_item;
   logic [ColW-1:0]   seq_col;

   // Stage 1: line memory read data arrives here.
   logic              v1_ff;
   ccf_pkg::item_type item1_ff;
   logic [PixW-1:0]   pix1_ff;
   logic [ColW-1:0]   addr1_ff;
   logic [PixW-1:0]   older_rd;
   logic [PixW-1:0]   newer_rd;
   logic              store_wr;

   // Stage 2: products registered inside the filter.
   logic              v2_ff;
   ccf_pkg::item_type item2_ff;
   logic [PixW-1:0]   filter_pix;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff    <= ccf_pkg::CoefTopReset;
         coef_middle_ff <= ccf_pkg::CoefMiddleReset;
         coef_bottom_ff <= ccf_pkg::CoefBottomReset;
         width_ff       <= ccf_pkg::WidthReset;
         height_ff      <= ccf_pkg::HeightReset;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.reg_index)
            ccf_pkg::REG_COEF_TOP: begin
               coef_top_ff <= csr_chan.wr_data;
            end
            ccf_pkg::REG_COEF_MIDDLE: begin
               coef_middle_ff <= csr_chan.wr_data;
            end
            ccf_pkg::REG_COEF_BOTTOM: begin
               coef_bottom_ff <= csr_chan.wr_data;
            end
            ccf_pkg::REG_IMAGE_WIDTH: begin
               width_ff <= csr_chan.wr_data[ccf_pkg::WidthW-1:0];
            end
            ccf_pkg::REG_IMAGE_HEIGHT: begin
               height_ff <= csr_chan.wr_data[ccf_pkg::HeightW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Widths below three act as three, widths above the line memory depth as
   // that depth; heights below three act as three.
   always_comb begin
      if (width_ff < 11'd3) begin
         w_last = ColW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_last = ColW'(MAX_WIDTH - 1);
      end else begin
         w_last = ColW'(width_ff - 11'd1);
      end
      h_eff = (height_ff < 16'd3) ? 16'd3 : height_ff;
   end

   // A stage advances when it is empty or the stage after it advances.
   assign en2            = !v2_ff || out_free;
   assign en1            = !v1_ff || en2;
   assign req_chan.ready = en1;
   assign req_fire       = req_chan.valid && en1;

   ccf_sequencer #(
      .ColW (ColW)
   ) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .drain  (req_chan.drain),
      .w_last (w_last),
      .h_eff  (h_eff),
      .item   (seq_item),
      .col    (seq_col)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_fire;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         item1_ff <= seq_item;
         pix1_ff  <= req_chan.pixel_in;
         addr1_ff <= seq_col;
      end
      if (en2) begin
         item2_ff <= item1_ff;
      end
   end

   // The older row takes the newer row's entry, the newer row the new pixel.
   assign store_wr = en2 && v1_ff && item1_ff.write_px;

   ccf_line_ram #(
      .Depth (MAX_WIDTH)
   ) u_line_older (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (addr1_ff),
      .wr_data (newer_rd),
      .rd_en   (en1),
      .rd_addr (seq_col),
      .rd_data (older_rd)
   );

   ccf_line_ram #(
      .Depth (MAX_WIDTH)
   ) u_line_newer (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (addr1_ff),
      .wr_data (pix1_ff),
      .rd_en   (en1),
      .rd_addr (seq_col),
      .rd_data (newer_rd)
   );

   ccf_filter u_filter (
      .clock       (clock),
      .shift_en    (store_wr),
      .prod_en     (en2),
      .cur         ({pix1_ff, newer_rd, older_rd}),
      .coef_top    (coef_top_ff),
      .coef_middle (coef_middle_ff),
      .coef_bottom (coef_bottom_ff),
      .pixel_val   (filter_pix)
   );

   ccf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .item      (item2_ff),
      .pixel_val (filter_pix),
      .free      (out_free),
      .rsp_chan  (rsp_chan)
   );

endmodule
